// ===== src/upe_pkg.sv =====
`default_nettype none

package upe_pkg;

    // Kind of result run that one code unit produces.
    typedef enum logic [2:0] {
        RUN_PASS = 3'b001,
        RUN_HEX  = 3'b010,
        RUN_ERR  = 3'b100
    } upe_kind_t;

    // Position inside the three characters that escape one byte.
    typedef enum logic [2:0] {
        PH_PCT = 3'b001,
        PH_HI  = 3'b010,
        PH_LO  = 3'b100
    } upe_phase_t;

    localparam logic [6:0] CHAR_PERCENT = 7'h25;
    localparam logic [15:0] LOW_SURR_MIN  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_MAX  = 16'hDFFF;
    localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
    localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;
    localparam logic [15:0] TWO_BYTE_MIN  = 16'h0800;
    localparam logic [15:0] ASCII_LIMIT   = 16'h0080;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_unit;
    } upe_unit_t;

    // One run of results: a passed character, an error, or up to four escaped bytes.
    typedef struct packed {
        upe_kind_t       kind;
        logic [6:0]      ch;
        logic [3:0][7:0] bytes;
        logic [1:0]      nb_m1;
        logic            last;
    } upe_run_t;

    function automatic logic [6:0] hex_digit(input logic [3:0] nib);
        logic [6:0] d;
        if (nib < 4'd10)
            d = 7'h30 + {3'b000, nib};
        else
            d = 7'h37 + {3'b000, nib};
        return d;
    endfunction

    function automatic logic comp_char(input logic [6:0] c);
        logic ok;
        ok = 1'b0;
        if (c >= 7'h61 && c <= 7'h7A)
            ok = 1'b1;
        if (c >= 7'h41 && c <= 7'h5A)
            ok = 1'b1;
        if (c >= 7'h30 && c <= 7'h39)
            ok = 1'b1;
        case (c)
            7'h2D, 7'h5F, 7'h2E, 7'h21, 7'h7E, 7'h2A, 7'h27, 7'h28, 7'h29: ok = 1'b1;
            default: ;
        endcase
        return ok;
    endfunction

    function automatic logic extra_char(input logic [6:0] c);
        logic ok;
        case (c)
            7'h3B, 7'h2F, 7'h3F, 7'h3A, 7'h40, 7'h26, 7'h3D, 7'h2B, 7'h24, 7'h2C, 7'h23:
                ok = 1'b1;
            default:
                ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

`default_nettype wire

// ===== src/upe_ifs.sv =====
`default_nettype none

interface upe_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        last_unit;

    modport source (output valid, output code_unit, output last_unit, input ready);
    modport sink (input valid, input code_unit, input last_unit, output ready);
endinterface

interface upe_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       run_last;
    logic       string_end;
    logic       error;

    modport source (output valid, output out_char, output run_last, output string_end,
                    output error, input ready);
    modport sink (input valid, input out_char, input run_last, input string_end,
                  input error, output ready);
endinterface

interface upe_cfg_if;
    logic valid;
    logic ready;
    logic set_select;

    modport source (output valid, output set_select, input ready);
    modport sink (input valid, input set_select, output ready);
endinterface

`default_nettype wire

// ===== src/upe_decode.sv =====
`default_nettype none

module upe_decode (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              set_select,
    input  wire upe_pkg::upe_unit_t unit,
    input  wire logic              take,
    output upe_pkg::upe_run_t      run,
    output logic                   produce
);

    logic [9:0] pending_high_reg;
    logic [9:0] pending_high_next;
    logic       pending_valid_reg;
    logic       pending_valid_next;
    logic       error_seen_reg;
    logic       error_seen_next;

    logic [15:0] u;
    logic        last;
    logic        is_low;
    logic        is_high;
    logic        allowed;
    logic [20:0] cp;

    assign u       = unit.code_unit;
    assign last    = unit.last_unit;
    assign is_low  = (u >= upe_pkg::LOW_SURR_MIN) && (u <= upe_pkg::LOW_SURR_MAX);
    assign is_high = (u >= upe_pkg::HIGH_SURR_MIN) && (u <= upe_pkg::HIGH_SURR_MAX);
    assign allowed = (u < upe_pkg::ASCII_LIMIT)
                     && (upe_pkg::comp_char(u[6:0])
                         || (set_select && upe_pkg::extra_char(u[6:0])));
    assign cp = upe_pkg::SUPP_BASE + {1'b0, pending_high_reg, u[9:0]};

    always_comb
    begin
        pending_high_next  = pending_high_reg;
        pending_valid_next = pending_valid_reg;
        error_seen_next    = error_seen_reg;
        produce            = 1'b1;
        run.kind           = upe_pkg::RUN_ERR;
        run.ch             = 7'd0;
        run.bytes          = '0;
        run.nb_m1          = 2'd0;
        run.last           = last;

        if (error_seen_reg)
        begin
            // Drop the rest of a failed string; its last unit reports once.
            produce = last;
            if (last)
                error_seen_next = 1'b0;
        end
        else if (pending_valid_reg)
        begin
            pending_valid_next = 1'b0;
            pending_high_next  = 10'd0;
            if (!is_low)
                error_seen_next = !last;
            else
            begin
                run.kind     = upe_pkg::RUN_HEX;
                run.nb_m1    = 2'd3;
                run.bytes[0] = {5'b11110, cp[20:18]};
                run.bytes[1] = {2'b10, cp[17:12]};
                run.bytes[2] = {2'b10, cp[11:6]};
                run.bytes[3] = {2'b10, cp[5:0]};
            end
        end
        else if (allowed)
        begin
            run.kind = upe_pkg::RUN_PASS;
            run.ch   = u[6:0];
        end
        else if (is_low)
            error_seen_next = !last;
        else if (is_high)
        begin
            if (!last)
            begin
                produce            = 1'b0;
                pending_high_next  = u[9:0];
                pending_valid_next = 1'b1;
            end
        end
        else
        begin
            run.kind = upe_pkg::RUN_HEX;
            if (u < upe_pkg::ASCII_LIMIT)
            begin
                run.nb_m1    = 2'd0;
                run.bytes[0] = u[7:0];
            end
            else if (u < upe_pkg::TWO_BYTE_MIN)
            begin
                run.nb_m1    = 2'd1;
                run.bytes[0] = {3'b110, u[10:6]};
                run.bytes[1] = {2'b10, u[5:0]};
            end
            else
            begin
                run.nb_m1    = 2'd2;
                run.bytes[0] = {4'b1110, u[15:12]};
                run.bytes[1] = {2'b10, u[11:6]};
                run.bytes[2] = {2'b10, u[5:0]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_high_reg  <= 10'd0;
            pending_valid_reg <= 1'b0;
            error_seen_reg    <= 1'b0;
        end
        else if (take)
        begin
            pending_high_reg  <= pending_high_next;
            pending_valid_reg <= pending_valid_next;
            error_seen_reg    <= error_seen_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/uri_utf8_percent_encoder.sv =====
`default_nettype none
// A unit passes the input register, the run register and the output register before its
// first character appears on chars. Units that pass through unchanged go at one code unit
// per cycle while chars.ready stays high; an escaped unit holds the run register for three
// characters per UTF-8 byte (3 to 12 characters), and a held high surrogate gives no output.
// Reset: rst_n clears all valid flags, the surrogate and error state, and set_select to 0.
module uri_utf8_percent_encoder (
    input  wire logic clk,
    input  wire logic rst_n,
    upe_unit_if.sink  units,
    upe_char_if.source chars,
    upe_cfg_if.sink   cfg
);

    logic                 set_sel_reg;
    logic                 in_vld_reg;
    upe_pkg::upe_unit_t   in_reg;
    logic                 run_vld_reg;
    upe_pkg::upe_run_t    run_reg;
    logic [1:0]           idx_reg;
    upe_pkg::upe_phase_t  phase_reg;
    logic                 out_vld_reg;
    logic [6:0]           out_char_reg;
    logic                 run_last_reg;
    logic                 string_end_reg;
    logic                 error_reg;

    upe_pkg::upe_run_t    dec_run;
    logic                 dec_produce;
    logic                 emit;
    logic                 at_end;
    logic                 run_free;
    logic                 take;
    logic [7:0]           cur_byte;
    logic [6:0]           cur_char;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            set_sel_reg <= 1'b0;
        else if (cfg.valid)
            set_sel_reg <= cfg.set_select;
    end

    upe_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .set_select (set_sel_reg),
        .unit       (in_reg),
        .take       (take),
        .run        (dec_run),
        .produce    (dec_produce)
    );

    assign cur_byte = run_reg.bytes[idx_reg];
    assign at_end   = (run_reg.kind != upe_pkg::RUN_HEX)
                      || ((idx_reg == run_reg.nb_m1) && (phase_reg == upe_pkg::PH_LO));
    assign emit     = run_vld_reg && (!out_vld_reg || chars.ready);
    assign run_free = !run_vld_reg || (emit && at_end);
    assign take     = in_vld_reg && run_free;
    assign units.ready = !in_vld_reg || take;

    always_comb
    begin
        case (run_reg.kind)
            upe_pkg::RUN_PASS: cur_char = run_reg.ch;
            upe_pkg::RUN_HEX:
            begin
                case (phase_reg)
                    upe_pkg::PH_PCT: cur_char = upe_pkg::CHAR_PERCENT;
                    upe_pkg::PH_HI:  cur_char = upe_pkg::hex_digit(cur_byte[7:4]);
                    upe_pkg::PH_LO:  cur_char = upe_pkg::hex_digit(cur_byte[3:0]);
                    default:         cur_char = 7'd0;
                endcase
            end
            default: cur_char = 7'd0;
        endcase
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (units.ready)
            in_vld_reg <= units.valid;
    end

    always_ff @(posedge clk)
    begin
        if (units.ready && units.valid)
        begin
            in_reg.code_unit <= units.code_unit;
            in_reg.last_unit <= units.last_unit;
        end
    end

    // Run register and its character position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_vld_reg <= 1'b0;
            idx_reg     <= 2'd0;
            phase_reg   <= upe_pkg::PH_PCT;
        end
        else if (take && dec_produce)
        begin
            run_vld_reg <= 1'b1;
            idx_reg     <= 2'd0;
            phase_reg   <= upe_pkg::PH_PCT;
        end
        else if (emit)
        begin
            if (at_end)
                run_vld_reg <= 1'b0;
            else if (phase_reg == upe_pkg::PH_LO)
            begin
                phase_reg <= upe_pkg::PH_PCT;
                idx_reg   <= idx_reg + 2'd1;
            end
            else if (phase_reg == upe_pkg::PH_PCT)
                phase_reg <= upe_pkg::PH_HI;
            else
                phase_reg <= upe_pkg::PH_LO;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && dec_produce)
            run_reg <= dec_run;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (emit)
            out_vld_reg <= 1'b1;
        else if (chars.ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_char_reg   <= cur_char;
            run_last_reg   <= at_end;
            string_end_reg <= at_end && run_reg.last;
            error_reg      <= (run_reg.kind == upe_pkg::RUN_ERR);
        end
    end

    assign chars.valid      = out_vld_reg;
    assign chars.out_char   = out_char_reg;
    assign chars.run_last   = run_last_reg;
    assign chars.string_end = string_end_reg;
    assign chars.error      = error_reg;

endmodule

`default_nettype wire

// ===== test/percent_stream_checker.sv =====
module percent_stream_checker (
    input  logic clk,
    input  logic rst_n,
    upe_unit_if  units,
    upe_char_if  chars,
    upe_cfg_if   cfg,
    output int   mismatches,
    output int   results_due
);

    typedef struct packed {
        logic [6:0] ch;
        logic       run_last;
        logic       string_end;
        logic       error;
    } char_exp_t;

    string unreserved_chars = {"abcdefghijklmnopqrstuvwxyz",
                               "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_.!~*'()"};
    string uri_marks = ";/?:@&=+$,#";
    string hex_upper = "0123456789ABCDEF";

    char_exp_t expected_chars[$];
    char_exp_t run_buf[$];
    logic      use_full_set;
    logic [9:0] held_high;
    logic      held_valid;
    logic      dropping;
    int        results_seen;

    task automatic report_mismatch(input string what, input int got, input int want_v);
        if (mismatches < 40)
            $display("mismatch at result %0d: %s got %0h expected %0h",
                     results_seen, what, got, want_v);
        mismatches++;
    endtask

    function automatic bit is_allowed(input logic [15:0] u, input logic full);
        bit hit;
        hit = 1'b0;
        if (u < upe_pkg::ASCII_LIMIT) begin
            for (int i = 0; i < unreserved_chars.len(); i++)
                if (unreserved_chars[i] == u[7:0])
                    hit = 1'b1;
            if (full)
                for (int i = 0; i < uri_marks.len(); i++)
                    if (uri_marks[i] == u[7:0])
                        hit = 1'b1;
        end
        return hit;
    endfunction

    task automatic push_char(input logic [6:0] ch, input logic err);
        char_exp_t entry;
        entry = '{ch: ch, run_last: 1'b0, string_end: 1'b0, error: err};
        run_buf.push_back(entry);
    endtask

    // One UTF-8 byte goes out as a percent sign and two uppercase hex digits.
    task automatic push_escaped(input logic [7:0] b);
        byte digit;
        push_char(upe_pkg::CHAR_PERCENT, 1'b0);
        digit = hex_upper[int'(b[7:4])];
        push_char(digit[6:0], 1'b0);
        digit = hex_upper[int'(b[3:0])];
        push_char(digit[6:0], 1'b0);
    endtask

    task automatic surrogate_error(input logic last);
        held_valid = 1'b0;
        held_high = '0;
        dropping = !last;
        push_char(7'd0, 1'b1);
    endtask

    task automatic encode_unit(input logic [15:0] u, input logic last);
        logic      low_surr;
        logic      high_surr;
        logic [20:0] cp;
        char_exp_t tail;
        low_surr = (u >= upe_pkg::LOW_SURR_MIN) && (u <= upe_pkg::LOW_SURR_MAX);
        high_surr = (u >= upe_pkg::HIGH_SURR_MIN) && (u <= upe_pkg::HIGH_SURR_MAX);
        run_buf.delete();
        if (dropping) begin
            // A failed string is silent until its last unit closes it with one error.
            if (last) begin
                dropping = 1'b0;
                push_char(7'd0, 1'b1);
            end
        end else if (held_valid) begin
            if (!low_surr) begin
                surrogate_error(last);
            end else begin
                cp = upe_pkg::SUPP_BASE + {1'b0, held_high, 10'd0} + {11'd0, u[9:0]};
                held_valid = 1'b0;
                held_high = '0;
                push_escaped({5'b11110, cp[20:18]});
                push_escaped({2'b10, cp[17:12]});
                push_escaped({2'b10, cp[11:6]});
                push_escaped({2'b10, cp[5:0]});
            end
        end else if (is_allowed(u, use_full_set)) begin
            push_char(u[6:0], 1'b0);
        end else if (low_surr) begin
            surrogate_error(last);
        end else if (high_surr) begin
            if (last) begin
                surrogate_error(1'b1);
            end else begin
                held_high = u[9:0];
                held_valid = 1'b1;
            end
        end else if (u < upe_pkg::ASCII_LIMIT) begin
            push_escaped(u[7:0]);
        end else if (u < upe_pkg::TWO_BYTE_MIN) begin
            push_escaped({3'b110, u[10:6]});
            push_escaped({2'b10, u[5:0]});
        end else begin
            push_escaped({4'b1110, u[15:12]});
            push_escaped({2'b10, u[11:6]});
            push_escaped({2'b10, u[5:0]});
        end
        if (run_buf.size() > 0) begin
            tail = run_buf.pop_back();
            tail.run_last = 1'b1;
            tail.string_end = last;
            run_buf.push_back(tail);
        end
        foreach (run_buf[i])
            expected_chars.push_back(run_buf[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        char_exp_t want;
        if (!rst_n) begin
            expected_chars.delete();
            use_full_set = 1'b0;
            held_high = '0;
            held_valid = 1'b0;
            dropping = 1'b0;
            results_seen = 0;
            mismatches = 0;
            results_due <= 0;
        end else begin
            if (cfg.valid && cfg.ready)
                use_full_set = cfg.set_select;
            if (chars.valid && chars.ready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch("result with nothing expected, out_char",
                                    int'(chars.out_char), 0);
                end else begin
                    want = expected_chars.pop_front();
                    if (chars.out_char !== want.ch)
                        report_mismatch("out_char", int'(chars.out_char), int'(want.ch));
                    if (chars.run_last !== want.run_last)
                        report_mismatch("run_last", int'(chars.run_last),
                                        int'(want.run_last));
                    if (chars.string_end !== want.string_end)
                        report_mismatch("string_end", int'(chars.string_end),
                                        int'(want.string_end));
                    if (chars.error !== want.error)
                        report_mismatch("error", int'(chars.error), int'(want.error));
                end
                results_seen++;
            end
            if (units.valid && units.ready)
                encode_unit(units.code_unit, units.last_unit);
            results_due <= expected_chars.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
module tb_top;

    localparam int CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   results_due;
    int   burst_left;
    int   units_sent;
    int   hold_asks;
    int   holds_done;

    string plain_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_.!~*'()";
    string uri_marks = ";/?:@&=+$,#";

    upe_unit_if units();
    upe_char_if chars();
    upe_cfg_if  cfg();

    uri_utf8_percent_encoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .units (units),
        .chars (chars),
        .cfg   (cfg)
    );

    percent_stream_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .units       (units),
        .chars       (chars),
        .cfg         (cfg),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // The sender leaves the last request on the bus after its handshake; the next
    // call either replaces it in the same step or lowers valid for a gap.
    task automatic send_unit(input logic [15:0] cu, input logic lu);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
            if (gap > 0) begin
                units.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 10);
        end
        units.valid <= 1'b1;
        units.code_unit <= cu;
        units.last_unit <= lu;
        @(posedge clk);
        while (!units.ready)
            @(posedge clk);
        burst_left--;
        units_sent++;
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
    endtask

    task automatic write_set(input logic full);
        units.valid <= 1'b0;
        burst_left = 0;
        wait_drained();
        // A held high surrogate produces nothing, so give the block time to settle.
        repeat (8) @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.set_select <= full;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_single(input int roll);
        logic [15:0] u;
        if (roll < 50) begin
            if ($urandom_range(0, 3) == 0)
                u = {8'd0, uri_marks[$urandom_range(0, uri_marks.len() - 1)]};
            else
                u = {8'd0, plain_chars[$urandom_range(0, plain_chars.len() - 1)]};
        end else if (roll < 62) begin
            u = 16'($urandom_range(0, 16'h007F));
        end else if (roll < 75) begin
            u = 16'($urandom_range(16'h0080, 16'h07FF));
        end else if (roll < 88) begin
            if ($urandom_range(0, 1) == 0)
                u = 16'($urandom_range(16'h0800, 16'hD7FF));
            else
                u = 16'($urandom_range(16'hE000, 16'hFFFF));
        end else if (roll < 94) begin
            u = 16'($urandom_range(upe_pkg::LOW_SURR_MIN, upe_pkg::LOW_SURR_MAX));
        end else if (roll < 97) begin
            u = 16'($urandom_range(upe_pkg::HIGH_SURR_MIN, upe_pkg::HIGH_SURR_MAX));
        end else begin
            u = 16'($urandom);
        end
        return u;
    endfunction

    task automatic send_string(input int len);
        int left;
        int roll;
        left = len;
        while (left > 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 12 && left >= 2) begin
                send_unit(16'($urandom_range(upe_pkg::HIGH_SURR_MIN, upe_pkg::HIGH_SURR_MAX)),
                          1'b0);
                send_unit(16'($urandom_range(upe_pkg::LOW_SURR_MIN, upe_pkg::LOW_SURR_MAX)),
                          left == 2);
                left -= 2;
            end else begin
                send_unit(pick_single(roll), left == 1);
                left--;
            end
        end
    endtask

    task automatic send_random(input int target);
        while (units_sent < target)
            send_string($urandom_range(1, 8));
    endtask

    // Receiver: ready steps through four patterns in turn, except while
    // a requested hold-off keeps it low.
    initial
    begin
        int rcv_cycle;
        int hold_left;
        rcv_cycle = 0;
        hold_left = 0;
        holds_done = 0;
        chars.ready = 1'b0;
        forever begin
            @(posedge clk);
            rcv_cycle++;
            if (hold_left > 0) begin
                hold_left--;
                chars.ready <= 1'b0;
            end else if (holds_done != hold_asks) begin
                holds_done++;
                hold_left = 150;
                chars.ready <= 1'b0;
            end else begin
                case ((rcv_cycle / 50) % 4)
                    0: chars.ready <= 1'b1;
                    1: chars.ready <= 1'($urandom_range(0, 1));
                    2: chars.ready <= ($urandom_range(0, 7) != 0);
                    default: chars.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        units.valid = 1'b0;
        units.code_unit = '0;
        units.last_unit = 1'b0;
        cfg.valid = 1'b0;
        cfg.set_select = 1'b0;
        burst_left = 0;
        units_sent = 0;
        hold_asks = 0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_set(1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'h003B, 1'b0);
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        // Smallest and largest surrogate pairs.
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDFFF, 1'b1);
        // Lone low surrogate mid-string: the rest is dropped up to the last unit.
        send_unit(16'hDC00, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'h0023, 1'b1);
        // High surrogate followed by a plain unit that ends the string.
        send_unit(16'hD800, 1'b0);
        send_unit(16'h0041, 1'b1);
        // High surrogate as the last unit, then a lone low one as the last unit.
        send_unit(16'hDBFF, 1'b1);
        send_unit(16'hDFFF, 1'b1);
        // Two high surrogates in a row.
        send_unit(16'hD811, 1'b0);
        send_unit(16'hD800, 1'b0);
        send_unit(16'h007E, 1'b1);
        // The set changes in the middle of a string.
        send_unit(16'h0024, 1'b0);
        write_set(1'b1);
        send_unit(16'h0023, 1'b0);
        send_unit(16'h003B, 1'b0);
        send_unit(16'h0040, 1'b1);

        send_random(115);
        write_set(1'b0);
        hold_asks++;
        send_random(210);
        write_set(1'b1);
        send_random(300);
        write_set(1'b0);
        send_random(390);

        units.valid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && results_due == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
